FILE: hdl/trapezoidal_energy_filter_macros.svh
// Assertion macros shared by the trapezoidal energy filter.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef TRAPEZOIDAL_ENERGY_FILTER_MACROS_SVH
`define TRAPEZOIDAL_ENERGY_FILTER_MACROS_SVH

`define TEF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define TEF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/tef_pkg.sv
`default_nettype none

package tef_pkg;

  localparam int unsigned HISTORY_DEPTH_DEF = 1024;
  localparam int unsigned SAMPLE_BITS_DEF   = 16;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned LEN_W      = 8;
  localparam int unsigned DLY_W      = 10;
  localparam int unsigned SUM_W      = 24;
  localparam int unsigned PEAK_W     = 25;
  localparam int unsigned OUT_W      = 26;

  localparam logic [LEN_W-1:0]  LEN_RST  = LEN_W'(50);
  localparam logic [DLY_W-1:0]  FILL_CAP = DLY_W'(1023);
  localparam logic [PEAK_W-1:0] PEAK_MIN = {1'b1, {(PEAK_W-1){1'b0}}};

  localparam int unsigned NUM_TAPS  = 3;
  localparam int unsigned TAP_LATE  = 0;
  localparam int unsigned TAP_MID   = 1;
  localparam int unsigned TAP_EARLY = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RISE_LEN = 1'b0,
    CFG_GAP_LEN  = 1'b1
  } cfg_idx_e;

  // Fill thresholds: late tap, middle tap, both windows full.
  typedef struct packed {
    logic [DLY_W-1:0] late;
    logic [DLY_W-1:0] mid;
    logic [DLY_W-1:0] full;
  } thr_t;

  typedef struct packed {
    logic en_late;
    logic en_mid;
    logic en_early;
    logic full;
  } gate_t;

  typedef struct packed {
    logic [SUM_W-1:0] late_sum;
    logic [SUM_W-1:0] early_sum;
    logic             full;
    logic             last;
  } s2_word_t;

endpackage

`default_nettype wire

FILE: hdl/trapezoidal_energy_filter.sv
// Trapezoidal energy filter for digitised pulse records.
// Input channel: one sample word per handshake (sample_i, pulse_end_i), taken at a
// clock edge with in_valid_i high and in_stall_o low. pulse_end_i marks the last
// sample of a record.
// Output channel: one result word per handshake, taken with out_valid_o high and
// out_stall_i low. A word is produced for every sample with both windows full and
// for every last sample; other samples produce nothing.
// Configuration: rise_len (index 0) and gap_len (index 1), written through
// cfg_we_i, cfg_idx_i and cfg_wdata_i while no sample is in flight.
// Throughput is one sample per clock while in_stall_o is low. Each sample reads
// three history taps from two memories with registered reads, then moves through
// the stage-1 registers, the stage-2 word and, for a word, the output register.
// Reset sets both lengths to 50 and clears the sums, fill count and peak; the
// history memories are not cleared and need no clearing pass.
// When the receiver stalls, the three pipeline registers fill and in_stall_o
// rises once no free slot remains; no word is lost or repeated.
`default_nettype none

`include "trapezoidal_energy_filter_macros.svh"

module trapezoidal_energy_filter #(
  parameter int unsigned HISTORY_DEPTH = tef_pkg::HISTORY_DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS   = tef_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [tef_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [tef_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]       sample_i,
  input  logic                                pulse_end_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [tef_pkg::OUT_W-1:0]    filter_value_o,
  output logic                                value_valid_o,
  output logic signed [tef_pkg::OUT_W-1:0]    peak_value_o,
  output logic                                peak_found_o,
  output logic                                is_last_o
);
  import tef_pkg::*;

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);

  thr_t                                  thr;
  logic [NUM_TAPS-1:0][AW-1:0]           tap_off;
  logic [NUM_TAPS-1:0][SAMPLE_BITS-1:0]  tap_w;

  logic                    in_fire;
  logic [DLY_W-1:0]        fill_q, fill_d;
  gate_t                   gate_d;

  logic                    s1_v_q, s1_v_d, s1_adv, s1_take;
  logic signed [SUM_W-1:0] s1_x_q;
  logic                    s1_last_q;
  gate_t                   s1_gate_q;

  logic signed [SUM_W-1:0] late_q, early_q, late_new, early_new;
  logic signed [SUM_W-1:0] tap_late, tap_mid, tap_early;

  logic                    s2_v_q, s2_v_d, s2_take;
  s2_word_t                s2_word_q;

  tef_cfg #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .thr_o      (thr),
    .tap_off_o  (tap_off)
  );

  tef_hist #(
    .HISTORY_DEPTH(HISTORY_DEPTH),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_hist (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (in_fire),
    .sample_i (sample_i),
    .tap_off_i(tap_off),
    .tap_o    (tap_w)
  );

  assign in_stall_o = !s1_take;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_comb begin
    gate_d.en_late  = (fill_q >= thr.late);
    gate_d.en_mid   = (fill_q >= thr.mid);
    gate_d.en_early = (fill_q > thr.full);
    gate_d.full     = (fill_q >= thr.full);
    if (pulse_end_i) begin
      fill_d = '0;
    end else if (fill_q < FILL_CAP) begin
      fill_d = fill_q + DLY_W'(1);
    end else begin
      fill_d = fill_q;
    end
  end

  always_comb begin
    tap_late  = s1_gate_q.en_late  ? SUM_W'($signed(tap_w[TAP_LATE]))  : '0;
    tap_mid   = s1_gate_q.en_mid   ? SUM_W'($signed(tap_w[TAP_MID]))   : '0;
    tap_early = s1_gate_q.en_early ? SUM_W'($signed(tap_w[TAP_EARLY])) : '0;
    late_new  = late_q + s1_x_q - tap_late;
    early_new = early_q + tap_mid - tap_early;
    s1_adv    = s1_v_q && s2_take;
    s1_take   = !s1_v_q || s1_adv;
    s1_v_d    = in_fire || (s1_v_q && !s1_adv);
    s2_v_d    = s1_adv || (s2_v_q && !s2_take);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      late_q  <= '0;
      early_q <= '0;
    end else begin
      s1_v_q <= s1_v_d;
      s2_v_q <= s2_v_d;
      if (in_fire) begin
        fill_q <= fill_d;
      end
      if (s1_adv) begin
        late_q  <= s1_last_q ? '0 : late_new;
        early_q <= s1_last_q ? '0 : early_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_x_q    <= SUM_W'(sample_i);
      s1_last_q <= pulse_end_i;
      s1_gate_q <= gate_d;
    end
    if (s1_adv) begin
      s2_word_q.late_sum  <= late_new;
      s2_word_q.early_sum <= early_new;
      s2_word_q.full      <= s1_gate_q.full;
      s2_word_q.last      <= s1_last_q;
    end
  end

  tef_peak u_peak (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s2_valid_i    (s2_v_q),
    .s2_word_i     (s2_word_q),
    .s2_take_o     (s2_take),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .filter_value_o(filter_value_o),
    .value_valid_o (value_valid_o),
    .peak_value_o  (peak_value_o),
    .peak_found_o  (peak_found_o),
    .is_last_o     (is_last_o)
  );

  `TEF_ASSERT_NXT(a_fill_clear, in_fire && pulse_end_i, fill_q == '0, "fill count not cleared at pulse end")
  `TEF_ASSERT_NXT(a_sum_clear, s1_adv && s1_last_q, (late_q == '0) && (early_q == '0), "sums not cleared at pulse end")
  `TEF_ASSERT_IMP(a_peak_bound, out_valid_o && value_valid_o, peak_found_o && (peak_value_o >= filter_value_o), "peak below current filter value")

endmodule

`default_nettype wire

FILE: hdl/tef_cfg.sv
`default_nettype none

module tef_cfg #(
  parameter int unsigned HISTORY_DEPTH = tef_pkg::HISTORY_DEPTH_DEF,
  localparam int unsigned AW = $clog2(HISTORY_DEPTH)
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [tef_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [tef_pkg::CFG_DATA_W-1:0]        cfg_wdata_i,
  output tef_pkg::thr_t                         thr_o,
  output logic [tef_pkg::NUM_TAPS-1:0][AW-1:0]  tap_off_o
);
  import tef_pkg::*;

  localparam int unsigned RW = DLY_W + 6;

  typedef logic [NUM_TAPS-1:0][AW-1:0] off_t;

  function automatic logic [AW-1:0] reduce(input logic [DLY_W-1:0] dly);
    logic [RW-1:0] v;
    v = RW'(dly);
    for (int k = 3; k >= 0; k--) begin
      if (v >= RW'(HISTORY_DEPTH << k)) begin
        v = v - RW'(HISTORY_DEPTH << k);
      end
    end
    return v[AW-1:0];
  endfunction

  function automatic thr_t make_thr(input logic [LEN_W-1:0] rise,
                                    input logic [LEN_W-1:0] gap);
    thr_t t;
    t.late = DLY_W'(rise) + DLY_W'(1);
    t.mid  = DLY_W'(rise) + DLY_W'(gap);
    t.full = t.mid + DLY_W'(rise);
    return t;
  endfunction

  function automatic off_t make_off(input thr_t t);
    off_t o;
    o[TAP_LATE]  = reduce(t.late);
    o[TAP_MID]   = reduce(t.mid);
    o[TAP_EARLY] = reduce(t.full + DLY_W'(1));
    return o;
  endfunction

  logic [LEN_W-1:0] rise_q, rise_d;
  logic [LEN_W-1:0] gap_q, gap_d;
  thr_t             thr_q, thr_d;
  off_t             off_q, off_d;

  always_comb begin
    rise_d = rise_q;
    gap_d  = gap_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_RISE_LEN: rise_d = cfg_wdata_i[LEN_W-1:0];
        CFG_GAP_LEN:  gap_d  = cfg_wdata_i[LEN_W-1:0];
        default: ;
      endcase
    end
    thr_d = make_thr(rise_d, gap_d);
    off_d = make_off(thr_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rise_q <= LEN_RST;
      gap_q  <= LEN_RST;
      thr_q  <= make_thr(LEN_RST, LEN_RST);
      off_q  <= make_off(make_thr(LEN_RST, LEN_RST));
    end else begin
      rise_q <= rise_d;
      gap_q  <= gap_d;
      thr_q  <= thr_d;
      off_q  <= off_d;
    end
  end

  assign thr_o     = thr_q;
  assign tap_off_o = off_q;

endmodule

`default_nettype wire

FILE: hdl/tef_hist.sv
`default_nettype none

module tef_hist #(
  parameter int unsigned HISTORY_DEPTH = tef_pkg::HISTORY_DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS   = tef_pkg::SAMPLE_BITS_DEF,
  localparam int unsigned AW = $clog2(HISTORY_DEPTH)
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           wr_en_i,
  input  logic [SAMPLE_BITS-1:0]                         sample_i,
  input  logic [tef_pkg::NUM_TAPS-1:0][AW-1:0]           tap_off_i,
  output logic [tef_pkg::NUM_TAPS-1:0][SAMPLE_BITS-1:0]  tap_o
);
  import tef_pkg::*;

  // Two copies of the history give three read ports between them.
  logic [SAMPLE_BITS-1:0] mem_a [HISTORY_DEPTH];
  logic [SAMPLE_BITS-1:0] mem_b [HISTORY_DEPTH];

  logic [AW-1:0]                 wp_q, wp_d;
  logic [NUM_TAPS-1:0][AW:0]     addr_diff;
  logic [NUM_TAPS-1:0][AW-1:0]   rd_addr;
  logic [NUM_TAPS-1:0]           fwd_q;
  logic [SAMPLE_BITS-1:0]        x_q;
  logic [SAMPLE_BITS-1:0]        rd_late_q, rd_mid_q, rd_early_q;

  always_comb begin
    for (int i = 0; i < NUM_TAPS; i++) begin
      addr_diff[i] = {1'b0, wp_q} - {1'b0, tap_off_i[i]};
      if (addr_diff[i][AW]) begin
        rd_addr[i] = addr_diff[i][AW-1:0] + AW'(HISTORY_DEPTH);
      end else begin
        rd_addr[i] = addr_diff[i][AW-1:0];
      end
    end
    wp_d = (wp_q == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_q + AW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
    end else if (wr_en_i) begin
      wp_q <= wp_d;
    end
  end

  // A zero offset points at the entry being written in the same cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      x_q <= sample_i;
      for (int i = 0; i < NUM_TAPS; i++) begin
        fwd_q[i] <= (tap_off_i[i] == '0);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_a[wp_q] <= sample_i;
      rd_late_q   <= mem_a[rd_addr[TAP_LATE]];
      rd_mid_q    <= mem_a[rd_addr[TAP_MID]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_b[wp_q] <= sample_i;
      rd_early_q  <= mem_b[rd_addr[TAP_EARLY]];
    end
  end

  assign tap_o[TAP_LATE]  = fwd_q[TAP_LATE]  ? x_q : rd_late_q;
  assign tap_o[TAP_MID]   = fwd_q[TAP_MID]   ? x_q : rd_mid_q;
  assign tap_o[TAP_EARLY] = fwd_q[TAP_EARLY] ? x_q : rd_early_q;

endmodule

`default_nettype wire

FILE: hdl/tef_peak.sv
`default_nettype none

module tef_peak (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s2_valid_i,
  input  tef_pkg::s2_word_t                   s2_word_i,
  output logic                                s2_take_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [tef_pkg::OUT_W-1:0]    filter_value_o,
  output logic                                value_valid_o,
  output logic signed [tef_pkg::OUT_W-1:0]    peak_value_o,
  output logic                                peak_found_o,
  output logic                                is_last_o
);
  import tef_pkg::*;

  logic signed [PEAK_W-1:0] diff;
  logic signed [PEAK_W-1:0] peak_q, peak_nx;
  logic                     seen_q, seen_nx;
  logic                     emit, out_free, s2_adv;
  logic                     out_valid_q, out_valid_d;

  logic signed [OUT_W-1:0]  filter_q, peak_out_q;
  logic                     vv_q, found_q, last_q;

  always_comb begin
    diff = PEAK_W'($signed(s2_word_i.late_sum)) - PEAK_W'($signed(s2_word_i.early_sum));
    peak_nx = peak_q;
    if (s2_word_i.full && (!seen_q || (diff > peak_q))) begin
      peak_nx = diff;
    end
    seen_nx     = seen_q | s2_word_i.full;
    emit        = s2_word_i.full | s2_word_i.last;
    out_free    = !out_valid_q || !out_stall_i;
    s2_adv      = s2_valid_i && (!emit || out_free);
    out_valid_d = (out_valid_q && out_stall_i) || (s2_adv && emit);
  end

  assign s2_take_o = !s2_valid_i || s2_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      peak_q      <= PEAK_MIN;
      seen_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (s2_adv) begin
        if (s2_word_i.last) begin
          peak_q <= PEAK_MIN;
          seen_q <= 1'b0;
        end else begin
          peak_q <= peak_nx;
          seen_q <= seen_nx;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv && emit) begin
      filter_q   <= s2_word_i.full ? OUT_W'(diff) : '0;
      vv_q       <= s2_word_i.full;
      peak_out_q <= seen_nx ? OUT_W'(peak_nx) : '0;
      found_q    <= seen_nx;
      last_q     <= s2_word_i.last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign filter_value_o = filter_q;
  assign value_valid_o  = vv_q;
  assign peak_value_o   = peak_out_q;
  assign peak_found_o   = found_q;
  assign is_last_o      = last_q;

endmodule

`default_nettype wire
